>>> rtl/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and widths for the segment crossing point unit.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int CW  = 16;          // coordinate width
  localparam int DW  = 2 * CW + 3;  // den width: difference of two products of differences
  localparam int NW  = 3 * CW + 5;  // numerator width
  localparam int QW  = NW;          // quotient register width

  typedef struct packed {
    logic signed [CW-1:0] first_start_x;
    logic signed [CW-1:0] first_start_y;
    logic signed [CW-1:0] first_end_x;
    logic signed [CW-1:0] first_end_y;
    logic signed [CW-1:0] second_start_x;
    logic signed [CW-1:0] second_start_y;
    logic signed [CW-1:0] second_end_x;
    logic signed [CW-1:0] second_end_y;
  } scp_in_t;

  typedef struct packed {
    logic                 crossed;
    logic                 degenerate;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } scp_out_t;

  // per-item control carried down the divider pipeline
  typedef struct packed {
    logic vld;
    logic hit;
    logic degen;
    logic neg_x;
    logic neg_y;
  } scp_ctl_t;

endpackage

>>> rtl/segment_cross_point_unit.sv
`timescale 1ns / 1ps
// Pipeline: 4 front stages + 53 divider stages + 1 output stage.
// Throughput: one item per cycle; busy is always low after reset.
// The depth is set by the shared-divisor divider, one quotient bit per stage.
// Reset (synchronous, rst high) clears all valid bits; no result is in flight.
// The receiver cannot stall: each result shows for one cycle with done high.
// ----------------------------------------------------------------------------
// segment_cross_point_unit
// Box test, straddle tests and exact crossing point of two integer segments.
// ----------------------------------------------------------------------------
module segment_cross_point_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  scp_pkg::scp_in_t    item,
  output logic                done,
  output scp_pkg::scp_out_t   result
);
  import scp_pkg::*;

  localparam int PW = 2 * CW + 2;  // product of two differences
  localparam int OW = 2 * CW + 3;  // orientation

  assign busy = 1'b0;

  // stage 1: differences and box test
  logic                 v1;
  logic signed [CW:0]   d_bax, d_aby, d_dcx, d_cdy, d_acy, d_dcy, d_aby2;
  logic signed [CW:0]   d_dbx, d_cdx, d_bay, d_cax, d_dax, d_bcy;
  logic signed [CW-1:0] ax1, ay1, bx1, by1, cx1, dy1;
  logic                 box1;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  always_comb begin
    ax = item.first_start_x;  ay = item.first_start_y;
    bx = item.first_end_x;    by = item.first_end_y;
    cx = item.second_start_x; cy = item.second_start_y;
    dx = item.second_end_x;   dy = item.second_end_y;
  end

  function automatic logic signed [CW-1:0] mn(logic signed [CW-1:0] a,
                                              logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction
  function automatic logic signed [CW-1:0] mx(logic signed [CW-1:0] a,
                                              logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    ax1 <= ax; ay1 <= ay; bx1 <= bx; by1 <= by;
    cx1 <= cx; dy1 <= dy;
    d_bax  <= {bx[CW-1], bx} - {ax[CW-1], ax};
    d_aby  <= {ay[CW-1], ay} - {by[CW-1], by};
    d_dcx  <= {dx[CW-1], dx} - {cx[CW-1], cx};
    d_cdy  <= {cy[CW-1], cy} - {dy[CW-1], dy};
    d_acy  <= {ay[CW-1], ay} - {cy[CW-1], cy};
    d_dcy  <= {dy[CW-1], dy} - {cy[CW-1], cy};
    d_aby2 <= {by[CW-1], by} - {ay[CW-1], ay};
    d_dbx  <= {dx[CW-1], dx} - {bx[CW-1], bx};
    d_cdx  <= {cx[CW-1], cx} - {dx[CW-1], dx};
    d_bay  <= {by[CW-1], by} - {ay[CW-1], ay};
    d_cax  <= {cx[CW-1], cx} - {ax[CW-1], ax};
    d_dax  <= {dx[CW-1], dx} - {ax[CW-1], ax};
    d_bcy  <= {by[CW-1], by} - {cy[CW-1], cy};
    box1 <= (mn(ax, bx) <= mx(cx, dx)) && (mn(cx, dx) <= mx(ax, bx)) &&
            (mn(ay, by) <= mx(cy, dy)) && (mn(cy, dy) <= mx(ay, by));
  end

  // stage 2: products
  // orient(a,b,c) = (by-ay)(cx-ax) - (bx-ax)(cy-ay)
  // orient(c,d,a) = (dy-cy)(ax-cx) - (dx-cx)(ay-cy)
  logic                 v2, box2;
  logic signed [PW-1:0] p_o1a, p_o1b, p_o2a, p_o2b, p_o3a, p_o3b, p_o4a, p_o4b;
  logic signed [PW-1:0] p_den_a, p_den_b;
  logic signed [PW-1:0] p_nx_a, p_nx_b, p_nx_c, p_ny_a, p_ny_b, p_ny_c;
  logic signed [CW:0]   s_dcx, s_bax, s_dcy, s_aby;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    box2  <= box1;
    // c against ab, d against ab
    p_o1a <= d_bax * (-d_acy);
    p_o1b <= d_bay * d_cax;
    p_o2a <= d_bax * $signed({dy1[CW-1], dy1} - {ay1[CW-1], ay1});
    p_o2b <= d_bay * d_dax;
    // a against cd, b against cd
    p_o3a <= d_dcx * d_acy;
    p_o3b <= d_dcy * (-d_cax);
    p_o4a <= d_dcx * d_bcy;
    p_o4b <= d_dcy * $signed({bx1[CW-1], bx1} - {cx1[CW-1], cx1});
    p_den_a <= d_dcx * d_aby;
    p_den_b <= d_bax * d_cdy;
    // x numerator terms (each to be times one more factor)
    p_nx_a <= d_acy * d_bax;                        // * dcx
    p_nx_b <= $signed({cx1[CW-1], cx1}) * d_dcy;    // * bax
    p_nx_c <= $signed({ax1[CW-1], ax1}) * d_aby2;   // * dcx
    // y numerator terms
    p_ny_a <= $signed({by1[CW-1], by1}) * (-d_bax); // * dcy
    p_ny_b <= d_dbx * d_dcy;                        // * aby
    p_ny_c <= $signed({dy1[CW-1], dy1}) * d_cdx;    // * bay
    s_dcx <= d_dcx; s_bax <= d_bax; s_dcy <= d_dcy; s_aby <= d_aby;
  end

  // stage 3: orientations, den, triple products
  logic                 v3, box3;
  logic signed [OW-1:0] o1, o2, o3, o4, den3;
  logic signed [NW-1:0] nxa, nxb, nxc, nya, nyb, nyc;
  logic signed [CW:0]   t_bay;

  always_comb t_bay = -s_aby;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    box3 <= box2;
    o1   <= OW'(p_o1b) - OW'(p_o1a);
    o2   <= OW'(p_o2b) - OW'(p_o2a);
    o3   <= OW'(p_o3b) - OW'(p_o3a);
    o4   <= OW'(p_o4b) - OW'(p_o4a);
    den3 <= OW'(p_den_a) - OW'(p_den_b);
    nxa  <= p_nx_a * s_dcx;
    nxb  <= p_nx_b * s_bax;
    nxc  <= p_nx_c * s_dcx;
    nya  <= p_ny_a * s_dcy;
    nyb  <= p_ny_b * s_aby;
    nyc  <= p_ny_c * t_bay;
  end

  // stage 4: sign tests, numerators, magnitudes
  function automatic logic strad(logic signed [OW-1:0] a,
                                 logic signed [OW-1:0] b);
    return ((a == '0) && (b == '0)) || (a[OW-1] != b[OW-1]);
  endfunction

  logic signed [NW-1:0] numx, numy, dy_neg;
  logic signed [OW-1:0] den_y;
  logic                 hit3;
  scp_ctl_t             ctl4;
  logic [NW-1:0]        mx4, my4;
  logic [DW-1:0]        md4;

  always_comb begin
    hit3   = box3 && strad(o1, o2) && strad(o3, o4);
    numx   = nxa + nxb - nxc;
    numy   = nya + nyb - nyc;
    den_y  = -den3;
    dy_neg = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.vld <= 1'b0;
    end else begin
      ctl4.vld <= v3;
    end
    ctl4.hit   <= hit3;
    ctl4.degen <= hit3 && (den3 == '0);
    ctl4.neg_x <= numx[NW-1] ^ den3[OW-1];
    ctl4.neg_y <= numy[NW-1] ^ den_y[OW-1];
    mx4 <= numx[NW-1] ? NW'(dy_neg - numx) : NW'(numx);
    my4 <= numy[NW-1] ? NW'(dy_neg - numy) : NW'(numy);
    md4 <= den3[OW-1] ? DW'(-den3) : DW'(den3);
  end

  // divider
  scp_ctl_t      ctl_d;
  logic [QW-1:0] qx, qy;

  scp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl4),
    .num_x   (mx4),
    .num_y   (my4),
    .den     (md4),
    .ctl_out (ctl_d),
    .quo_x   (qx),
    .quo_y   (qy)
  );

  // output stage
  logic          ok;
  logic [QW-1:0] sx, sy;

  always_comb begin
    ok = ctl_d.hit && !ctl_d.degen;
    sx = ctl_d.neg_x ? (QW'(0) - qx) : qx;
    sy = ctl_d.neg_y ? (QW'(0) - qy) : qy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d.vld;
    end
    result.crossed    <= ctl_d.hit;
    result.degenerate <= ctl_d.degen;
    result.cross_x    <= ok ? sx[CW-1:0] : '0;
    result.cross_y    <= ok ? sy[CW-1:0] : '0;
  end

endmodule

>>> rtl/scp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_div
// Pipelined restoring divider for two unsigned quotients that share a
// divisor, one quotient bit per stage, one item accepted every cycle.
// ----------------------------------------------------------------------------
module scp_div (
  input  logic                     clk,
  input  logic                     rst,
  input  scp_pkg::scp_ctl_t        ctl_in,
  input  logic [scp_pkg::NW-1:0]   num_x,
  input  logic [scp_pkg::NW-1:0]   num_y,
  input  logic [scp_pkg::DW-1:0]   den,
  output scp_pkg::scp_ctl_t        ctl_out,
  output logic [scp_pkg::QW-1:0]   quo_x,
  output logic [scp_pkg::QW-1:0]   quo_y
);
  import scp_pkg::*;

  localparam int RW = DW + 1;

  scp_ctl_t         ctl [NW+1];
  logic [NW-1:0]    qx  [NW+1];
  logic [NW-1:0]    qy  [NW+1];
  logic [RW-1:0]    rx  [NW+1];
  logic [RW-1:0]    ry  [NW+1];
  logic [DW-1:0]    dv  [NW+1];

  always_comb begin
    ctl[0] = ctl_in;
    qx[0]  = num_x;
    qy[0]  = num_y;
    rx[0]  = '0;
    ry[0]  = '0;
    dv[0]  = den;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [RW:0]   tx, ty;
    logic [RW:0]   sub_x, sub_y;
    always_comb begin
      tx    = {rx[s], qx[s][NW-1]};
      ty    = {ry[s], qy[s][NW-1]};
      sub_x = tx - {2'b00, dv[s]};
      sub_y = ty - {2'b00, dv[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].vld <= 1'b0;
      end else begin
        ctl[s+1].vld <= ctl[s].vld;
      end
      ctl[s+1].hit   <= ctl[s].hit;
      ctl[s+1].degen <= ctl[s].degen;
      ctl[s+1].neg_x <= ctl[s].neg_x;
      ctl[s+1].neg_y <= ctl[s].neg_y;
      dv[s+1]        <= dv[s];
      rx[s+1] <= sub_x[RW] ? tx[RW-1:0] : sub_x[RW-1:0];
      ry[s+1] <= sub_y[RW] ? ty[RW-1:0] : sub_y[RW-1:0];
      qx[s+1] <= {qx[s][NW-2:0], ~sub_x[RW]};
      qy[s+1] <= {qy[s][NW-2:0], ~sub_y[RW]};
    end
  end

  assign ctl_out = ctl[NW];
  assign quo_x   = qx[NW];
  assign quo_y   = qy[NW];

endmodule

>>> rtl/scp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks on the segment crossing point unit, bound to the top.
// ----------------------------------------------------------------------------
module scp_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input scp_pkg::scp_out_t result
);
  import scp_pkg::*;

  a_degen_crossed: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |-> result.crossed)
    else $error("degenerate without crossed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.crossed |-> (result.cross_x == '0) && (result.cross_y == '0))
    else $error("nonzero point on miss");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |-> (result.cross_x == '0) && (result.cross_y == '0))
    else $error("nonzero point on collinear");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  a_reset_quiet: assert property (@(posedge clk) !rst && $past(rst) |-> !done)
    else $error("done right after reset");

endmodule

bind segment_cross_point_unit scp_checker u_scp_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);
